// File: sv/dbwc_pkg.sv
// ----------------------------------------------------------------------------
// dbwc_pkg
// Types and fixed constants for the delay-based window controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dbwc_pkg;

	localparam int WIN_W  = 32;
	localparam int TIME_W = 64;
	localparam int OUT_W  = 16;
	localparam int CFG_W  = 32;
	localparam int IDX_W  = 2;

	typedef logic [WIN_W-1:0]  win_t;
	typedef logic [TIME_W-1:0] time_t;

	// register indexes
	localparam logic [IDX_W-1:0] CFG_DELAY_THRESHOLD    = 2'd0;
	localparam logic [IDX_W-1:0] CFG_DECREASE_STEP      = 2'd1;
	localparam logic [IDX_W-1:0] CFG_INCREASE_NUMERATOR = 2'd2;
	localparam logic [IDX_W-1:0] CFG_INITIAL_WINDOW     = 2'd3;

	// event kinds
	localparam logic OP_SENT = 1'b0;
	localparam logic OP_ACK  = 1'b1;

	localparam logic [31:0] THRESH_RST   = 32'd80;
	localparam logic [15:0] INIT_WIN_RST = 16'd50;

endpackage

`default_nettype wire

// File: sv/delay_based_window_controller.sv
// ----------------------------------------------------------------------------
// delay_based_window_controller
// Congestion window kept in fixed point; halves on timeout sends, steps down
// on high ack delay and grows by numerator / window on low ack delay.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one event per beat: op,
//   timed_out, send_time, ack_time. Output channel (out_valid/out_ready)
//   returns one beat per event with window_whole, the integer window after
//   that event.
//   Configuration is written through cfg_we/cfg_index/cfg_data while idle;
//   writing initial_window also reloads the window.
//   A sent event passes the halve and done steps before out_valid. An
//   ack passes the delay compare, decrease and clamp steps, then the
//   divide and add steps when the delay is below the threshold, then done:
//   the increase is a restoring divide, one quotient bit per cycle through
//   the one shared add/subtract unit, which also does the decrease and the
//   saturating add. One event at a time; in_ready rises with out_valid.
//   The output register lets a new event be accepted while the last result
//   still waits; a finished event holds until that register is free, so a
//   stalled receiver stalls the block without loss.
//   Reset (arst_n low) loads the register reset values, sets the window to
//   initial_window shifted by FRACTION_BITS and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module delay_based_window_controller
	import dbwc_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              op,
	input  wire logic              timed_out,
	input  wire logic [TIME_W-1:0] send_time,
	input  wire logic [TIME_W-1:0] ack_time,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [OUT_W-1:0]       window_whole,
	input  wire logic              cfg_we,
	input  wire logic [IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data
);

	localparam int DIV_W = WIN_W - FRACTION_BITS;
	localparam logic [63:0] ONE64    = 64'd1 << FRACTION_BITS;
	localparam win_t        ONE_FIX  = WIN_W'(ONE64);
	localparam logic [WIN_W:0] TWO_FIX = (WIN_W+1)'(ONE64 << 1);
	localparam win_t DEC_RST = WIN_W'((64'd6 * ONE64 + 64'd5) / 64'd10);
	localparam win_t INC_RST = WIN_W'((64'd39 * ONE64 + 64'd5) / 64'd10);
	localparam logic [63:0] WRST64 = 64'(INIT_WIN_RST) << FRACTION_BITS;
	localparam win_t WIN_RST = (WRST64 > 64'hFFFF_FFFF) ? '1 : WIN_W'(WRST64);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_HALF  = 3'd1;
	localparam logic [2:0] S_DELAY = 3'd2;
	localparam logic [2:0] S_DEC   = 3'd3;
	localparam logic [2:0] S_CLAMP = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_ADD   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]       state_q;
	win_t             thresh_q, step_q, incn_q, win_q;
	logic             tmo_q, gt_q, lt_q;
	time_t            send_q, ack_q;
	logic [DIV_W-1:0] dvsr_q, rem_q;
	win_t             quo_q;
	logic [5:0]       cnt_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_q;

	// shared add/subtract unit
	logic [WIN_W:0]   alu_a, alu_b;
	logic             alu_sub;
	logic [WIN_W+1:0] alu_r;

	time_t            delay;
	logic [DIV_W:0]   rem_sh;
	logic [63:0]      load_w;
	win_t             load_sat;
	win_t             whole_shift;

	assign alu_r = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b}) : ({1'b0, alu_a} + {1'b0, alu_b});
	assign delay = ack_q - send_q;
	assign rem_sh = {rem_q, quo_q[WIN_W-1]};
	assign load_w = 64'(cfg_data[15:0]) << FRACTION_BITS;
	assign load_sat = (load_w > 64'hFFFF_FFFF) ? '1 : WIN_W'(load_w);
	assign whole_shift = win_q >> FRACTION_BITS;

	always_comb begin
		alu_a   = {1'b0, win_q};
		alu_b   = {1'b0, step_q};
		alu_sub = 1'b1;
		unique case (state_q)
			S_DIV: begin
				alu_a = (WIN_W+1)'(rem_sh);
				alu_b = (WIN_W+1)'(dvsr_q);
			end
			S_ADD: begin
				alu_b   = {1'b0, quo_q};
				alu_sub = 1'b0;
			end
			default: begin
			end
		endcase
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign window_whole = out_q;

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			tmo_q  <= timed_out;
			send_q <= send_time;
			ack_q  <= ack_time;
		end
		if (state_q == S_DONE && (!out_valid_q || out_ready))
			out_q <= whole_shift[OUT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thresh_q    <= THRESH_RST;
			step_q      <= DEC_RST;
			incn_q      <= INC_RST;
			win_q       <= WIN_RST;
			gt_q        <= 1'b0;
			lt_q        <= 1'b0;
			dvsr_q      <= '0;
			rem_q       <= '0;
			quo_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a done step refilling the register keeps it valid
			if (out_valid_q && out_ready && state_q != S_DONE)
				out_valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DELAY_THRESHOLD:    thresh_q <= cfg_data;
					CFG_DECREASE_STEP:      step_q   <= cfg_data;
					CFG_INCREASE_NUMERATOR: incn_q   <= cfg_data;
					CFG_INITIAL_WINDOW:     win_q    <= load_sat;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= (op == OP_ACK) ? S_DELAY : S_HALF;
				end
				S_HALF: begin
					if (tmo_q && ({1'b0, win_q} > TWO_FIX))
						win_q <= win_q >> 1;
					state_q <= S_DONE;
				end
				S_DELAY: begin
					gt_q    <= delay > time_t'(thresh_q);
					lt_q    <= delay < time_t'(thresh_q);
					state_q <= S_DEC;
				end
				S_DEC: begin
					// borrow means step exceeds window: saturate at zero
					if (gt_q)
						win_q <= alu_r[WIN_W+1] ? '0 : alu_r[WIN_W-1:0];
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					if (win_q < ONE_FIX) begin
						win_q  <= ONE_FIX;
						dvsr_q <= DIV_W'(1);
					end else begin
						dvsr_q <= whole_shift[DIV_W-1:0];
					end
					rem_q   <= '0;
					quo_q   <= incn_q;
					cnt_q   <= 6'(WIN_W);
					state_q <= lt_q ? S_DIV : S_DONE;
				end
				S_DIV: begin
					// restoring step; remainder stays below the divisor
					if (!alu_r[WIN_W+1]) begin
						rem_q <= alu_r[DIV_W-1:0];
						quo_q <= {quo_q[WIN_W-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[DIV_W-1:0];
						quo_q <= {quo_q[WIN_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1)
						state_q <= S_ADD;
				end
				S_ADD: begin
					win_q   <= alu_r[WIN_W] ? '1 : alu_r[WIN_W-1:0];
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
			endcase
		end
	end

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q != 6'd0))
		else $error("divide running with zero count");

	a_add_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD) |-> ($past(state_q) == S_DIV))
		else $error("add step not preceded by divide");

	a_div_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (win_q >= ONE_FIX && dvsr_q != '0))
		else $error("divide started on unclamped window");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != S_IDLE))
		else $error("accepted beat did not start work");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside done step");

endmodule

`default_nettype wire
